@@ design/ssm_pkg.sv @@
// Shared types and constants for the serial memory slave core.
// Holds opcodes, status masks, queue sizing and the command beat type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int MEM_DEPTH   = 1 << ADDR_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] OPC_WREN  = 8'h06;
    localparam logic [7:0] OPC_WRDI  = 8'h04;
    localparam logic [7:0] OPC_RDSR  = 8'h05;
    localparam logic [7:0] OPC_WRSR  = 8'h01;
    localparam logic [7:0] OPC_READ  = 8'h03;
    localparam logic [7:0] OPC_WRITE = 8'h02;

    localparam logic [7:0] SR_WRITABLE = 8'hBC;

    typedef enum logic [1:0] {
        K_DIRECT,
        K_READ,
        K_WRITE
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [ADDR_BITS-1:0]  addr;
        logic [7:0]            data;
        logic [7:0]            miso;
        logic                  ign;
    } t_cmd;

endpackage

`default_nettype wire

@@ design/ssm_ram.sv @@
// Generic single-port RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/ssm_front.sv @@
// Front end: decodes opcode, address and data beats and tracks command state.
// Emits one command beat per exchanged byte. Depends on ssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssm_front import ssm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic       i_op,
    input  wire logic [7:0] i_mosi_byte,
    output logic            o_push,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA,
        PH_SR_READ,
        PH_SR_WRITE,
        PH_TRAIL
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [7:0]           r_opcode, n_opcode;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic                 r_wel, n_wel;
    logic [7:0]           r_status, n_status;
    logic                 is_write_cmd;
    logic                 muted;
    logic [15:0]          hi_word;

    assign is_write_cmd = (r_opcode == OPC_WRITE) || (r_opcode == OPC_WRSR);
    assign muted        = is_write_cmd && !r_wel;
    assign hi_word      = {i_mosi_byte, 8'h00};

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_addr   = r_addr;
        n_wel    = r_wel;
        n_status = r_status;
        o_push   = 1'b0;
        o_cmd    = '{kind: K_DIRECT, addr: r_addr, data: i_mosi_byte,
                     miso: 8'h00, ign: 1'b0};
        if (i_take && i_op) begin
            if (r_phase != PH_IDLE && is_write_cmd) begin
                n_wel = 1'b0;
            end
            n_phase = PH_IDLE;
        end else if (i_take) begin
            o_push = 1'b1;
            case (r_phase)
                PH_IDLE: begin
                    n_opcode = i_mosi_byte;
                    case (i_mosi_byte)
                        OPC_WREN: begin
                            n_wel   = 1'b1;
                            n_phase = PH_TRAIL;
                        end
                        OPC_WRDI: begin
                            n_wel   = 1'b0;
                            n_phase = PH_TRAIL;
                        end
                        OPC_RDSR: n_phase = PH_SR_READ;
                        OPC_WRSR: begin
                            o_cmd.ign = !r_wel;
                            n_phase   = PH_SR_WRITE;
                        end
                        OPC_READ: n_phase = PH_ADDR_HI;
                        OPC_WRITE: begin
                            o_cmd.ign = !r_wel;
                            n_phase   = PH_ADDR_HI;
                        end
                        default: begin
                            o_cmd.ign = 1'b1;
                            n_phase   = PH_TRAIL;
                        end
                    endcase
                end
                PH_ADDR_HI: begin
                    n_addr    = ADDR_BITS'(hi_word);
                    o_cmd.ign = muted;
                    n_phase   = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_addr    = r_addr | ADDR_BITS'(i_mosi_byte);
                    o_cmd.ign = muted;
                    n_phase   = PH_DATA;
                end
                PH_DATA: begin
                    if (r_opcode == OPC_READ) begin
                        o_cmd.kind = K_READ;
                    end else if (!muted) begin
                        o_cmd.kind = K_WRITE;
                    end else begin
                        o_cmd.ign = 1'b1;
                    end
                    n_addr = r_addr + ADDR_BITS'(1);
                end
                PH_SR_READ: begin
                    o_cmd.miso = {r_status[7:2], r_wel, r_status[0]};
                end
                PH_SR_WRITE: begin
                    if (!muted) begin
                        n_status = (r_status & ~SR_WRITABLE) | (i_mosi_byte & SR_WRITABLE);
                    end else begin
                        o_cmd.ign = 1'b1;
                    end
                    n_phase = PH_TRAIL;
                end
                default: begin
                    o_cmd.ign = 1'b1;
                    n_phase   = PH_TRAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_opcode <= 8'h00;
            r_addr   <= '0;
            r_wel    <= 1'b0;
            r_status <= 8'h00;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_addr   <= n_addr;
            r_wel    <= n_wel;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

@@ design/ssm_queue.sv @@
// Short command queue between the front end and the back end.
// Flop-based ring with occupancy count. Depends on ssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssm_queue import ssm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd                 r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_head, r_tail;
    logic [QCNT_BITS-1:0] r_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_count <= r_count + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
        end
    end

endmodule

`default_nettype wire

@@ design/ssm_back.sv @@
// Back end: executes queued commands against the memory array and
// drives the result register. Depends on ssm_pkg and ssm_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssm_back import ssm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_cmd       i_cmd,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [7:0]      o_miso_byte,
    output logic            o_ignored
);

    logic       r_s1_valid;
    logic       r_s1_is_read;
    logic [7:0] r_s1_miso;
    logic       r_s1_ign;
    logic       r_out_valid;
    logic [7:0] r_out_miso;
    logic       r_out_ign;
    logic [7:0] rdata;
    logic       out_free, s1_adv, s1_free;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = !i_empty && s1_free;

    ssm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && (i_cmd.kind == K_WRITE)),
        .i_re    (o_pop && (i_cmd.kind == K_READ)),
        .i_addr  (i_cmd.addr),
        .i_wdata (i_cmd.data),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (o_pop) begin
            r_s1_is_read <= (i_cmd.kind == K_READ);
            r_s1_miso    <= i_cmd.miso;
            r_s1_ign     <= i_cmd.ign;
        end
        if (s1_adv) begin
            r_out_miso <= r_s1_is_read ? rdata : r_s1_miso;
            r_out_ign  <= r_s1_ign;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_miso_byte = r_out_miso;
    assign o_ignored   = r_out_ign;

endmodule

`default_nettype wire

@@ design/spi_serial_memory_slave_core.sv @@
// Serial memory slave core: byte-level opcode decode, status and memory access.
// A result passes through the command queue, the first back-end stage and the output register.
// Throughput: one beat per cycle while o_stall is low; the four-entry command queue sets the stall point.
// A release beat produces no result. The memory array has a single port.
// Synchronous active-low reset clears decode state, latch, status, the queue and result stages;
// memory contents are not cleared. Depends on ssm_pkg, ssm_front, ssm_queue, ssm_back.
`timescale 1ns / 1ps
`default_nettype none

module spi_serial_memory_slave_core import ssm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_op,
    input  wire logic [7:0] i_mosi_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_miso_byte,
    output logic            o_ignored
);

    logic push, pop, full, empty;
    t_cmd front_cmd, head_cmd;

    assign o_stall = full;

    ssm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (i_valid && !full),
        .i_op        (i_op),
        .i_mosi_byte (i_mosi_byte),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    ssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    ssm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_miso_byte (o_miso_byte),
        .o_ignored   (o_ignored)
    );

endmodule

`default_nettype wire

@@ design/ssm_checker.sv @@
// Port-level checker for the serial memory slave core, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module ssm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_op,
    input wire logic [7:0] i_mosi_byte,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_miso_byte,
    input wire logic       o_ignored
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_op) && $stable(i_mosi_byte))
        else $error("stalled input beat changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_miso_byte) && $stable(o_ignored))
        else $error("stalled result beat changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ignored |-> o_miso_byte == 8'h00)
        else $error("ignored beat returned nonzero data");

endmodule

bind spi_serial_memory_slave_core ssm_checker u_ssm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_op        (i_op),
    .i_mosi_byte (i_mosi_byte),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_miso_byte (o_miso_byte),
    .o_ignored   (o_ignored)
);

`default_nettype wire

@@ tb/tb_spi_serial_memory_slave_core.sv @@
// Self-checking testbench for spi_serial_memory_slave_core: byte beats in, result bytes out.
// Predicts each result from its own command decoder and memory image; depends on ssm_pkg.
`timescale 1ns / 1ps

module tb_spi_serial_memory_slave_core;
    import ssm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA,
        PH_SR_READ,
        PH_SR_WRITE,
        PH_TRAIL
    } t_phase;

    typedef struct packed {
        t_phase               ph;
        logic [7:0]           opc;
        logic [ADDR_BITS-1:0] addr;
        logic                 wel;
        logic [7:0]           sr;
    } t_slave_state;

    typedef struct packed {
        logic                 has_result;
        logic [7:0]           miso;
        logic                 ign;
        logic                 mem_rd;
        logic                 mem_wr;
        logic [ADDR_BITS-1:0] mem_addr;
    } t_step;

    typedef struct packed {
        logic       rel;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic [7:0] miso;
        logic       ign;
    } t_result;

    localparam int BEATS_PER_PHASE = 330;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    logic       i_op        = 1'b0;
    logic [7:0] i_mosi_byte = 8'h00;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    logic [7:0] o_miso_byte;
    logic       o_ignored;

    t_beat        beats_to_send[$];
    t_result      miso_due[$];
    int unsigned  written_addrs[$];
    bit           gen_written[MEM_DEPTH];
    logic [7:0]   mem_image[MEM_DEPTH];
    t_slave_state gen_state;
    t_slave_state chk_state;
    int           beats_queued   = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           mismatches     = 0;

    spi_serial_memory_slave_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_mosi_byte (i_mosi_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_miso_byte (o_miso_byte),
        .o_ignored   (o_ignored)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb_spi_serial_memory_slave_core failed");
        $finish;
    end

    function automatic t_step slave_step(inout t_slave_state s, input logic rel,
                                         input logic [7:0] b);
        t_step r;
        logic  wr_cmd;
        logic  muted;
        r = '0;
        wr_cmd = (s.opc == OPC_WRITE) || (s.opc == OPC_WRSR);
        if (rel) begin
            if (s.ph != PH_IDLE && wr_cmd) s.wel = 1'b0;
            s.ph = PH_IDLE;
            return r;
        end
        r.has_result = 1'b1;
        muted = wr_cmd && !s.wel;
        case (s.ph)
            PH_IDLE: begin
                s.opc = b;
                case (b)
                    OPC_WREN: begin
                        s.wel = 1'b1;
                        s.ph  = PH_TRAIL;
                    end
                    OPC_WRDI: begin
                        s.wel = 1'b0;
                        s.ph  = PH_TRAIL;
                    end
                    OPC_RDSR: s.ph = PH_SR_READ;
                    OPC_WRSR: begin
                        r.ign = !s.wel;
                        s.ph  = PH_SR_WRITE;
                    end
                    OPC_READ: s.ph = PH_ADDR_HI;
                    OPC_WRITE: begin
                        r.ign = !s.wel;
                        s.ph  = PH_ADDR_HI;
                    end
                    default: begin
                        r.ign = 1'b1;
                        s.ph  = PH_TRAIL;
                    end
                endcase
            end
            PH_ADDR_HI: begin
                s.addr = ADDR_BITS'({b, 8'h00});
                r.ign  = muted;
                s.ph   = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
                s.addr = s.addr | ADDR_BITS'(b);
                r.ign  = muted;
                s.ph   = PH_DATA;
            end
            PH_DATA: begin
                r.mem_addr = s.addr;
                if (s.opc == OPC_READ) begin
                    r.mem_rd = 1'b1;
                end else if (!muted) begin
                    r.mem_wr = 1'b1;
                end else begin
                    r.ign = 1'b1;
                end
                s.addr = s.addr + 1'b1;
            end
            PH_SR_READ: r.miso = {s.sr[7:2], s.wel, s.sr[0]};
            PH_SR_WRITE: begin
                if (!muted) s.sr = (s.sr & ~SR_WRITABLE) | (b & SR_WRITABLE);
                else r.ign = 1'b1;
                s.ph = PH_TRAIL;
            end
            default: begin
                r.ign = 1'b1;
                s.ph  = PH_TRAIL;
            end
        endcase
        return r;
    endfunction

    // Queue a beat unless it would read a location that was never written.
    function automatic bit queue_beat(input logic rel, input logic [7:0] b);
        t_slave_state nxt;
        t_step        st;
        nxt = gen_state;
        st  = slave_step(nxt, rel, b);
        if (st.mem_rd && !gen_written[st.mem_addr]) return 1'b0;
        gen_state = nxt;
        if (st.mem_wr && !gen_written[st.mem_addr]) begin
            gen_written[st.mem_addr] = 1'b1;
            written_addrs.push_back(int'(st.mem_addr));
        end
        beats_to_send.push_back('{rel, b});
        beats_queued++;
        return 1'b1;
    endfunction

    task automatic put(input logic rel, input logic [7:0] b);
        void'(queue_beat(rel, b));
    endtask

    task automatic put_addr(input logic [15:0] a);
        put(1'b0, a[15:8]);
        put(1'b0, a[7:0]);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic gen_command();
        int          kind;
        int          n;
        logic [15:0] a;
        logic        keep_open;
        kind      = $urandom_range(99);
        keep_open = ($urandom_range(19) == 0);
        case ($urandom_range(3))
            0:       a = 16'hFFF8 + 16'($urandom_range(7));
            1:       a = 16'($urandom_range(63));
            default: a = 16'($urandom);
        endcase
        if (kind < 25) begin
            put(1'b0, OPC_WREN);
            put(1'b1, 8'h00);
            put(1'b0, OPC_WRITE);
            put_addr(a);
            n = $urandom_range(8, 1);
            repeat (n) put(1'b0, 8'($urandom));
        end else if (kind < 50) begin
            put(1'b0, OPC_READ);
            if (written_addrs.size() != 0) begin
                a = 16'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
                put_addr(a);
                n = $urandom_range(8, 1);
                for (int k = 0; k < n; k++) begin
                    if (!queue_beat(1'b0, 8'($urandom))) break;
                end
            end else begin
                put_addr(a);
            end
        end else if (kind < 60) begin
            put(1'b0, OPC_RDSR);
            n = $urandom_range(4, 1);
            repeat (n) put(1'b0, 8'($urandom));
        end else if (kind < 70) begin
            if ($urandom_range(3) != 0) begin
                put(1'b0, OPC_WREN);
                put(1'b1, 8'h00);
            end
            put(1'b0, OPC_WRSR);
            put(1'b0, 8'($urandom));
            if ($urandom_range(3) == 0) put(1'b0, 8'($urandom));
        end else if (kind < 78) begin
            put(1'b0, $urandom_range(1) ? OPC_WREN : OPC_WRDI);
            n = $urandom_range(2);
            repeat (n) put(1'b0, 8'($urandom));
        end else if (kind < 85) begin
            put(1'b0, OPC_WRITE);
            put_addr(a);
            n = $urandom_range(4, 1);
            repeat (n) put(1'b0, 8'($urandom));
        end else begin
            n = $urandom_range(5, 1);
            repeat (n) begin
                if (!queue_beat($urandom_range(4) == 0, 8'($urandom))) put(1'b1, 8'h00);
            end
        end
        if (!keep_open) put(1'b1, 8'($urandom));
    endtask

    always @(posedge i_clk) begin : drive_beats
        t_beat nb;
        t_step st;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                st = slave_step(chk_state, i_op, i_mosi_byte);
                if (st.has_result)
                    miso_due.push_back('{st.mem_rd ? mem_image[st.mem_addr] : st.miso, st.ign});
                if (st.mem_wr) mem_image[st.mem_addr] = i_mosi_byte;
            end
            if (!i_valid || !o_stall) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nb = beats_to_send.pop_front();
                    i_valid     <= 1'b1;
                    i_op        <= nb.rel;
                    i_mosi_byte <= nb.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
            if (o_valid && !i_stall) begin
                if (miso_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result miso=%02h ignored=%b",
                                              o_miso_byte, o_ignored));
                end else begin
                    want = miso_due.pop_front();
                    if (o_miso_byte !== want.miso)
                        report_mismatch($sformatf("miso_byte %02h, want %02h",
                                                  o_miso_byte, want.miso));
                    if (o_ignored !== want.ign)
                        report_mismatch($sformatf("ignored %b, want %b",
                                                  o_ignored, want.ign));
                end
            end
        end
    end

    initial begin
        gen_state = '{PH_IDLE, 8'h00, '0, 1'b0, 8'h00};
        chk_state = gen_state;

        // release while idle, then status read with nothing set
        put(1'b1, 8'h00);
        put(1'b0, OPC_RDSR);
        put(1'b0, 8'hFF);
        put(1'b1, 8'h00);
        // write and status write while latch is clear
        put(1'b0, OPC_WRITE);
        put_addr(16'h0010);
        put(1'b0, 8'hAA);
        put(1'b1, 8'h00);
        put(1'b0, OPC_WRSR);
        put(1'b0, 8'hFF);
        put(1'b1, 8'h00);
        // set latch with a trailing byte, status write all ones with a trailing byte
        put(1'b0, OPC_WREN);
        put(1'b0, 8'h55);
        put(1'b1, 8'h00);
        put(1'b0, OPC_WRSR);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h00);
        put(1'b1, 8'h00);
        // write across the top of the array, read it back
        put(1'b0, OPC_WREN);
        put(1'b1, 8'h00);
        put(1'b0, OPC_WRITE);
        put_addr(16'hFFFF);
        put(1'b0, 8'h00);
        put(1'b0, 8'hFF);
        put(1'b1, 8'h00);
        put(1'b0, OPC_READ);
        put_addr(16'hFFFF);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b1, 8'h00);
        // clear latch, unknown opcodes at both extremes
        put(1'b0, OPC_WRDI);
        put(1'b1, 8'h00);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h5A);
        put(1'b1, 8'h00);
        put(1'b0, 8'h00);
        put(1'b1, 8'hFF);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int target = beats_queued + BEATS_PER_PHASE; beats_queued < target; )
                gen_command();
            // hold new beats until every result of this phase is back
            do @(negedge i_clk);
            while (beats_to_send.size() != 0 || i_valid || miso_due.size() != 0);
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_spi_serial_memory_slave_core passed");
        end else begin
            $display("tb_spi_serial_memory_slave_core failed");
        end
        $finish;
    end

endmodule
